FILE: rtl/xcrc_pkg.sv
// ----------------------------------------------------------------------------
// xcrc_pkg
// Shared types and protocol codes for the XMODEM-CRC receiver.
// ----------------------------------------------------------------------------
package xcrc_pkg;

   localparam logic [7:0]  CH_SOH = 8'h01;
   localparam logic [7:0]  CH_STX = 8'h02;
   localparam logic [7:0]  CH_EOT = 8'h04;
   localparam logic [7:0]  CH_ACK = 8'h06;
   localparam logic [7:0]  CH_NAK = 8'h15;
   localparam logic [7:0]  CH_REQ = 8'h43;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [15:0] TIMEOUT_RESET = 16'd300;
   localparam logic [9:0]  LAST_SHORT = 10'd127;
   localparam logic [9:0]  LAST_LONG = 10'd1023;
   localparam logic [32:0] SIZE_SHORT = 33'd128;
   localparam logic [32:0] SIZE_LONG = 33'd1024;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef enum logic [2:0] {
      PH_WAIT   = 3'd0,
      PH_HEADER = 3'd1,
      PH_SEQ1   = 3'd2,
      PH_SEQ2   = 3'd3,
      PH_DATA   = 3'd4,
      PH_CRC_HI = 3'd5,
      PH_CRC_LO = 3'd6,
      PH_DONE   = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      ST_NONE   = 3'd0,
      ST_GOOD   = 3'd1,
      ST_CRC    = 3'd2,
      ST_SEQ    = 3'd3,
      ST_REPEAT = 3'd4
   } status_type;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        data_valid;
      logic [7:0]  data_byte;
      logic [9:0]  data_offset;
      status_type  block_status;
      logic        transfer_done;
      logic [31:0] bytes_received;
   } rsp_type;

endpackage

FILE: rtl/xmodem_crc_receiver_core.sv
// ----------------------------------------------------------------------------
// xmodem_crc_receiver_core
// XMODEM receiver with CRC-16 block check, one result word per input word.
//
// req channel: one word per received serial byte (req_command 0, req_rx_byte)
// or per timer tick (req_command 1). rsp channel: exactly one word per req
// word, carrying the byte to send back ('C', ACK or NAK), a payload byte with
// its offset, the block verdict on the last trailer byte, the done flag and
// the running total of accepted payload bytes.
// csr channel: writes timeout_ticks, always ready; write only while idle.
// Each req word passes the input register, then the result register, before
// its result word appears on rsp. Throughput: one word per cycle while rsp_ready
// is high; the CRC byte update and the state logic sit between those two
// registers.
// Reset: waits for start, expects sequence 1, total 0, timeout 300.
// When rsp_ready is low the result register holds its word, the input
// register fills, and req_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module xmodem_crc_receiver_core
   import xcrc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [7:0]  req_rx_byte,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_data_valid,
   output logic [7:0]  rsp_data_byte,
   output logic [9:0]  rsp_data_offset,
   output logic [2:0]  rsp_block_status,
   output logic        rsp_transfer_done,
   output logic [31:0] rsp_bytes_received,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_timeout_ticks
);

   logic        in_valid_ff;
   logic        in_command_ff;
   logic [7:0]  in_byte_ff;
   logic        out_valid_ff;
   rsp_type     out_ff;
   logic [15:0] timeout_ff;
   rsp_type     rsp_in;
   logic        step;

   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         timeout_ff   <= TIMEOUT_RESET;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (step) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            timeout_ff <= csr_timeout_ticks;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_command_ff <= req_command;
         in_byte_ff    <= req_rx_byte;
      end
      if (step) begin
         out_ff <= rsp_in;
      end
   end

   xcrc_fsm u_fsm (
      .clock         (clock),
      .reset         (reset),
      .step_en       (step),
      .command       (in_command_ff),
      .rx_byte       (in_byte_ff),
      .timeout_ticks (timeout_ff),
      .rsp           (rsp_in)
   );

   assign rsp_valid          = out_valid_ff;
   assign rsp_tx_valid       = out_ff.tx_valid;
   assign rsp_tx_byte        = out_ff.tx_byte;
   assign rsp_data_valid     = out_ff.data_valid;
   assign rsp_data_byte      = out_ff.data_byte;
   assign rsp_data_offset    = out_ff.data_offset;
   assign rsp_block_status   = out_ff.block_status;
   assign rsp_transfer_done  = out_ff.transfer_done;
   assign rsp_bytes_received = out_ff.bytes_received;

   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.transfer_done |-> !out_ff.data_valid && out_ff.block_status == ST_NONE)
      else $error("payload or verdict after transfer end");

   a_tx_exclusive: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.data_valid |-> !out_ff.tx_valid)
      else $error("payload word also sends a reply byte");

   a_verdict_reply: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.block_status != ST_NONE |-> out_ff.tx_valid &&
      (out_ff.tx_byte == CH_ACK || out_ff.tx_byte == CH_NAK))
      else $error("block verdict without ACK or NAK");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && out_valid_ff && !rsp_ready)
      else $error("input stalled without output backpressure");

endmodule

FILE: rtl/xcrc_crc16.sv
// ----------------------------------------------------------------------------
// xcrc_crc16
// One-byte update of CRC-16/XMODEM, MSB first.
// ----------------------------------------------------------------------------
module xcrc_crc16
   import xcrc_pkg::*;
(
   input  logic [15:0] crc_in,
   input  logic [7:0]  data_in,
   output logic [15:0] crc_out
);

   always_comb begin
      logic [15:0] crc;
      crc = crc_in ^ {data_in, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (crc[15]) begin
            crc = {crc[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            crc = {crc[14:0], 1'b0};
         end
      end
      crc_out = crc;
   end

endmodule

FILE: rtl/xcrc_fsm.sv
// ----------------------------------------------------------------------------
// xcrc_fsm
// Transfer state machine: header, sequence, payload, CRC trailer, verdict.
// ----------------------------------------------------------------------------
module xcrc_fsm
   import xcrc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step_en,
   input  logic        command,
   input  logic [7:0]  rx_byte,
   input  logic [15:0] timeout_ticks,
   output rsp_type     rsp
);

   phase_type   phase_ff, phase_in;
   logic [15:0] start_count_ff, start_count_in;
   logic        block_long_ff, block_long_in;
   logic [9:0]  byte_count_ff, byte_count_in;
   logic [7:0]  seq_first_ff, seq_first_in;
   logic [7:0]  seq_second_ff, seq_second_in;
   logic [15:0] crc_running_ff, crc_running_in;
   logic [7:0]  crc_high_ff, crc_high_in;
   logic [7:0]  expected_seq_ff, expected_seq_in;
   logic [7:0]  last_good_ff, last_good_in;
   logic [31:0] total_ff, total_in;

   logic [15:0] crc_next;
   logic [15:0] start_inc;
   logic [32:0] total_sum;
   logic        seq_ok;
   logic        seq_repeat;

   xcrc_crc16 u_crc (
      .crc_in  (crc_running_ff),
      .data_in (rx_byte),
      .crc_out (crc_next)
   );

   assign start_inc  = start_count_ff + 16'd1;
   assign total_sum  = {1'b0, total_ff} + (block_long_ff ? SIZE_LONG : SIZE_SHORT);
   assign seq_ok     = (seq_first_ff == expected_seq_ff) && (seq_second_ff == ~expected_seq_ff);
   assign seq_repeat = (seq_first_ff == last_good_ff) && (seq_second_ff == ~last_good_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_WAIT;
         start_count_ff  <= '0;
         block_long_ff   <= 1'b0;
         byte_count_ff   <= '0;
         seq_first_ff    <= '0;
         seq_second_ff   <= '0;
         crc_running_ff  <= '0;
         crc_high_ff     <= '0;
         expected_seq_ff <= 8'd1;
         last_good_ff    <= '0;
         total_ff        <= '0;
      end else if (step_en) begin
         phase_ff        <= phase_in;
         start_count_ff  <= start_count_in;
         block_long_ff   <= block_long_in;
         byte_count_ff   <= byte_count_in;
         seq_first_ff    <= seq_first_in;
         seq_second_ff   <= seq_second_in;
         crc_running_ff  <= crc_running_in;
         crc_high_ff     <= crc_high_in;
         expected_seq_ff <= expected_seq_in;
         last_good_ff    <= last_good_in;
         total_ff        <= total_in;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      start_count_in  = start_count_ff;
      block_long_in   = block_long_ff;
      byte_count_in   = byte_count_ff;
      seq_first_in    = seq_first_ff;
      seq_second_in   = seq_second_ff;
      crc_running_in  = crc_running_ff;
      crc_high_in     = crc_high_ff;
      expected_seq_in = expected_seq_ff;
      last_good_in    = last_good_ff;
      total_in        = total_ff;
      rsp             = '0;

      if (command == CMD_TICK) begin
         if (phase_ff == PH_WAIT) begin
            if (start_count_ff == '0) begin
               rsp.tx_valid = 1'b1;
               rsp.tx_byte  = CH_REQ;
            end
            start_count_in = (start_inc >= timeout_ticks) ? '0 : start_inc;
         end
      end else begin
         case (phase_ff)
            PH_WAIT, PH_HEADER: begin
               if (rx_byte == CH_SOH || rx_byte == CH_STX) begin
                  block_long_in = (rx_byte == CH_STX);
                  phase_in      = PH_SEQ1;
               end else if (rx_byte == CH_EOT) begin
                  rsp.tx_valid = 1'b1;
                  rsp.tx_byte  = CH_ACK;
                  phase_in     = PH_DONE;
               end else begin
                  phase_in = PH_DONE;
               end
            end
            PH_SEQ1: begin
               seq_first_in = rx_byte;
               phase_in     = PH_SEQ2;
            end
            PH_SEQ2: begin
               seq_second_in  = rx_byte;
               crc_running_in = '0;
               byte_count_in  = '0;
               phase_in       = PH_DATA;
            end
            PH_DATA: begin
               rsp.data_valid  = 1'b1;
               rsp.data_byte   = rx_byte;
               rsp.data_offset = byte_count_ff;
               crc_running_in  = crc_next;
               if (byte_count_ff == (block_long_ff ? LAST_LONG : LAST_SHORT)) begin
                  phase_in = PH_CRC_HI;
               end
               byte_count_in = byte_count_ff + 10'd1;
            end
            PH_CRC_HI: begin
               crc_high_in = rx_byte;
               phase_in    = PH_CRC_LO;
            end
            PH_CRC_LO: begin
               rsp.tx_valid = 1'b1;
               if ({crc_high_ff, rx_byte} != crc_running_ff) begin
                  rsp.block_status = ST_CRC;
                  rsp.tx_byte      = CH_NAK;
               end else if (!seq_ok) begin
                  if (seq_repeat) begin
                     rsp.block_status = ST_REPEAT;
                     rsp.tx_byte      = CH_ACK;
                  end else begin
                     rsp.block_status = ST_SEQ;
                     rsp.tx_byte      = CH_NAK;
                  end
               end else begin
                  rsp.block_status = ST_GOOD;
                  rsp.tx_byte      = CH_ACK;
                  last_good_in     = expected_seq_ff;
                  expected_seq_in  = expected_seq_ff + 8'd1;
                  total_in         = total_sum[32] ? '1 : total_sum[31:0];
               end
               phase_in = PH_HEADER;
            end
            default: begin
            end
         endcase
      end

      rsp.transfer_done  = (phase_in == PH_DONE);
      rsp.bytes_received = total_in;
   end

endmodule
